// ===== rtl/core/wf_pkg.sv =====
// Shared types, register indexes, mode codes and small arithmetic helpers
// for the 3x3 window image filter. No dependencies.
`default_nettype none
package wf_pkg;

   typedef logic [2:0][7:0] pixel_type;   // [2] red, [1] green, [0] blue

   typedef struct packed {
      logic [8:0][2:0][7:0] cells;
      logic [2:0]           mode;
      logic                 emit;
      logic [10:0]          col;
      logic [10:0]          row;
      logic                 done;
   } job_type;

   typedef struct packed {
      pixel_type   px;
      logic [10:0] col;
      logic [10:0] row;
      logic        done;
   } result_type;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [2:0] MODE_GRAY    = 3'd0;
   localparam logic [2:0] MODE_MEDIAN  = 3'd1;
   localparam logic [2:0] MODE_GAUSS   = 3'd2;
   localparam logic [2:0] MODE_SOBEL_X = 3'd3;
   localparam logic [2:0] MODE_SOBEL_Y = 3'd4;

   localparam logic [2:0]  RESET_MODE   = MODE_MEDIAN;
   localparam logic [11:0] RESET_WIDTH  = 12'd640;
   localparam logic [11:0] RESET_HEIGHT = 12'd480;

   localparam int QUEUE_DEPTH = 16;

   function automatic logic [7:0] gray_of(input pixel_type p);
      logic [9:0]  sum;
      logic [20:0] prod;
      sum  = 10'(p[2]) + 10'(p[1]) + 10'(p[0]);
      prod = 21'(sum) * 21'd683;
      return prod[18:11];
   endfunction

   function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/window_3x3_image_filter.sv =====
// 3x3 window image filter: gray, median, Gaussian, Sobel X and Sobel Y.
// Instantiates wf_front, wf_back and wf_fifo; depends on wf_pkg.
//
// Usage:
//   Pixels enter in raster order on the req_ side: an item is taken on a
//   clock edge with push high and full low. req_frame_start marks column 0,
//   row 0. Results leave through a queue: while empty is low the oldest
//   result is on the rsp_ ports, and pop takes it.
//   Registers (mode, image_width, image_height) are written through csr_we,
//   csr_index and csr_wdata, by the user only while the block is idle; the
//   block does not enforce it. Throughput is one pixel per clock while full
//   is low. From accept to the rsp_ ports, the accepting edge reads the line
//   stores; a window update, two arithmetic stages and the queue write
//   follow. Non-border pixels give one result (gray mode gives one per
//   pixel). full rises when accepted items not yet popped or dropped reach
//   the queue depth (16), so a stalled receiver stops input without losing
//   work. Reset clears position, window, queue and registers; line stores
//   are not cleared and hold stale data until rewritten.
`default_nettype none
module window_3x3_image_filter #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   output logic              full,
   input  wire logic [7:0]   req_red_in,
   input  wire logic [7:0]   req_green_in,
   input  wire logic [7:0]   req_blue_in,
   input  wire logic         req_frame_start,
   output logic              empty,
   input  wire logic         pop,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_blue_out,
   output logic [10:0]       rsp_out_column,
   output logic [10:0]       rsp_out_row,
   output logic              rsp_frame_done,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [11:0]  csr_wdata
);
   import wf_pkg::*;

   localparam int OW = $clog2(QUEUE_DEPTH + 1);

   logic [2:0]   mode_ff;
   logic [11:0]  width_ff, height_ff;
   logic [OW-1:0] occ_ff;
   logic         accept, res_push, res_drop, job_valid, do_pop;
   pixel_type    px;
   job_type      job;
   result_type   res, rsp;

   assign full   = (occ_ff >= OW'(QUEUE_DEPTH));
   assign accept = push && !full;
   assign do_pop = pop && !empty;
   assign px     = {req_red_in, req_green_in, req_blue_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RESET_MODE;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:   mode_ff   <= csr_wdata[2:0];
            REG_WIDTH:  width_ff  <= csr_wdata;
            REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + OW'(accept) - OW'(do_pop) - OW'(res_drop);
      end
   end

   wf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .px          (px),
      .frame_start (req_frame_start),
      .mode        (mode_ff),
      .width_reg   (width_ff),
      .height_reg  (height_ff),
      .job_valid   (job_valid),
      .job         (job)
   );

   wf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .res_push  (res_push),
      .res_drop  (res_drop),
      .res       (res)
   );

   wf_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (res),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp)
   );

   assign rsp_red_out    = rsp.px[2];
   assign rsp_green_out  = rsp.px[1];
   assign rsp_blue_out   = rsp.px[0];
   assign rsp_out_column = rsp.col;
   assign rsp_out_row    = rsp.row;
   assign rsp_frame_done = rsp.done;

endmodule
`default_nettype wire

// ===== rtl/core/wf_front.sv =====
// Front part: position tracking, the two line stores and the 3x3 window.
// Emits one classified job per accepted pixel. Depends on wf_pkg.
`default_nettype none
module wf_front #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire wf_pkg::pixel_type  px,
   input  wire logic               frame_start,
   input  wire logic [2:0]         mode,
   input  wire logic [11:0]        width_reg,
   input  wire logic [11:0]        height_reg,
   output logic                    job_valid,
   output wf_pkg::job_type         job
);
   import wf_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int RW  = $clog2(MAX_HEIGHT);
   localparam int SWW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
   localparam int SWH = ($clog2(MAX_HEIGHT + 1) > 12) ? $clog2(MAX_HEIGHT + 1) : 12;

   logic [SWW-1:0] w_raw, w_eff;
   logic [SWH-1:0] h_raw, h_eff;
   logic [CW-1:0]  col_ff, col_in, c0, c1;
   logic [RW-1:0]  row_ff, row_in, r0, r2;
   logic [RW:0]    r1;
   logic           wrap_c, emit0, done0;

   pixel_type      up_mem  [MAX_WIDTH];
   pixel_type      mid_mem [MAX_WIDTH];
   pixel_type      up_rd_ff, mid_rd_ff, fwd_data_ff, px1_ff, up_eff;
   logic           s1_valid_ff, fwd_ff;
   logic [CW-1:0]  s1_col_ff;
   logic [2:0]     s1_mode_ff;
   logic           s1_emit_ff, s1_done_ff;
   logic [10:0]    s1_ocol_ff, s1_orow_ff;

   logic [8:0][2:0][7:0] win_ff, win_in;
   logic           job_valid_ff;
   job_type        job_ff;

   always_comb begin
      w_raw = SWW'(width_reg);
      h_raw = SWH'(height_reg);
      w_eff = (w_raw < SWW'(3)) ? SWW'(3) :
              ((w_raw > SWW'(MAX_WIDTH)) ? SWW'(MAX_WIDTH) : w_raw);
      h_eff = (h_raw < SWH'(3)) ? SWH'(3) :
              ((h_raw > SWH'(MAX_HEIGHT)) ? SWH'(MAX_HEIGHT) : h_raw);
      c0     = frame_start ? '0 : col_ff;
      r0     = frame_start ? '0 : row_ff;
      wrap_c = SWW'(c0) >= w_eff;
      c1     = wrap_c ? '0 : c0;
      r1     = wrap_c ? (RW+1)'(r0) + (RW+1)'(1) : (RW+1)'(r0);
      r2     = ((SWH+1)'(r1) >= (SWH+1)'(h_eff)) ? '0 : RW'(r1);
      if ((SWW+1)'(c1) + (SWW+1)'(1) >= (SWW+1)'(w_eff)) begin
         col_in = '0;
         row_in = ((SWH+1)'(r2) + (SWH+1)'(1) >= (SWH+1)'(h_eff)) ? '0 : RW'(r2 + RW'(1));
      end else begin
         col_in = c1 + CW'(1);
         row_in = r2;
      end
      emit0 = (mode == MODE_GRAY) ||
              ((mode >= MODE_MEDIAN) && (mode <= MODE_SOBEL_Y) &&
               (c1 >= CW'(2)) && (r2 >= RW'(2)));
      done0 = ((SWW+1)'(c1) + (SWW+1)'(1) == (SWW+1)'(w_eff)) &&
              ((SWH+1)'(r2) + (SWH+1)'(1) == (SWH+1)'(h_eff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_mem[c1] <= px;
         mid_rd_ff   <= mid_mem[c1];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         up_mem[s1_col_ff] <= mid_rd_ff;
      end
      if (accept) begin
         up_rd_ff <= up_mem[c1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_ff      <= s1_valid_ff && (s1_col_ff == c1);
         fwd_data_ff <= mid_rd_ff;
         px1_ff      <= px;
         s1_col_ff   <= c1;
         s1_mode_ff  <= mode;
         s1_emit_ff  <= emit0;
         s1_done_ff  <= done0;
         if (emit0 && (mode != MODE_GRAY)) begin
            s1_ocol_ff <= 11'(c1 - CW'(1));
            s1_orow_ff <= 11'(r2 - RW'(1));
         end else begin
            s1_ocol_ff <= 11'(c1);
            s1_orow_ff <= 11'(r2);
         end
      end
   end

   always_comb begin
      up_eff = fwd_ff ? fwd_data_ff : up_rd_ff;
      win_in = win_ff;
      for (int k = 0; k < 3; k++) begin
         win_in[3*k]   = win_ff[3*k+1];
         win_in[3*k+1] = win_ff[3*k+2];
      end
      win_in[2] = up_eff;
      win_in[5] = mid_rd_ff;
      win_in[8] = px1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= '0;
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         job_ff.cells <= win_in;
         job_ff.mode  <= s1_mode_ff;
         job_ff.emit  <= s1_emit_ff;
         job_ff.col   <= s1_ocol_ff;
         job_ff.row   <= s1_orow_ff;
         job_ff.done  <= s1_done_ff;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule
`default_nettype wire

// ===== rtl/core/wf_back.sv =====
// Back part: median, Gaussian, Sobel and gray arithmetic in two stages.
// Takes jobs from wf_front, hands results or drops. Depends on wf_pkg.
`default_nettype none
module wf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   input  wire wf_pkg::job_type  job,
   output logic                  res_push,
   output logic                  res_drop,
   output wf_pkg::result_type    res
);
   import wf_pkg::*;

   logic                 b1_valid_ff, b2_valid_ff;
   logic [2:0][2:0][7:0] lo_ff, md_ff, hi_ff;       // [row][channel]
   logic [2:0][11:0]     gsum_ff;
   logic [8:0][7:0]      gray_ff;
   logic [2:0]           b1_mode_ff, b2_mode_ff;
   logic                 b1_emit_ff, b2_emit_ff, b1_done_ff, b2_done_ff;
   logic [10:0]          b1_col_ff, b1_row_ff, b2_col_ff, b2_row_ff;

   logic [2:0][7:0]      lomax_ff, medmed_ff, himin_ff, gauss_ff;
   logic [7:0]           gpx_ff;
   logic signed [11:0]   sob_ff;

   logic [2:0][2:0][7:0] lo_in, md_in, hi_in;
   logic [2:0][11:0]     gsum_in;
   logic [8:0][7:0]      gray_in;
   logic [9:0]           pos_s, neg_s;
   logic signed [11:0]   gx, gy;
   logic [11:0]          sob_abs;
   logic [7:0]           sob_val;
   pixel_type            out_px;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 3; k++) begin
            lo_in[k][ch] = min2(min2(job.cells[3*k][ch], job.cells[3*k+1][ch]),
                                job.cells[3*k+2][ch]);
            hi_in[k][ch] = max2(max2(job.cells[3*k][ch], job.cells[3*k+1][ch]),
                                job.cells[3*k+2][ch]);
            md_in[k][ch] = med3(job.cells[3*k][ch], job.cells[3*k+1][ch],
                                job.cells[3*k+2][ch]);
         end
         gsum_in[ch] = 12'(job.cells[0][ch]) + 12'(job.cells[2][ch]) +
                       12'(job.cells[6][ch]) + 12'(job.cells[8][ch]) +
                       ((12'(job.cells[1][ch]) + 12'(job.cells[3][ch]) +
                         12'(job.cells[5][ch]) + 12'(job.cells[7][ch])) << 1) +
                       (12'(job.cells[4][ch]) << 2);
      end
      for (int i = 0; i < 9; i++) begin
         gray_in[i] = gray_of(job.cells[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= job_valid;
         b2_valid_ff <= b1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      md_ff      <= md_in;
      hi_ff      <= hi_in;
      gsum_ff    <= gsum_in;
      gray_ff    <= gray_in;
      b1_mode_ff <= job.mode;
      b1_emit_ff <= job.emit;
      b1_done_ff <= job.done;
      b1_col_ff  <= job.col;
      b1_row_ff  <= job.row;
   end

   always_comb begin
      if (b1_mode_ff == MODE_SOBEL_Y) begin
         pos_s = 10'(gray_ff[6]) + (10'(gray_ff[7]) << 1) + 10'(gray_ff[8]);
         neg_s = 10'(gray_ff[0]) + (10'(gray_ff[1]) << 1) + 10'(gray_ff[2]);
      end else begin
         pos_s = 10'(gray_ff[2]) + (10'(gray_ff[5]) << 1) + 10'(gray_ff[8]);
         neg_s = 10'(gray_ff[0]) + (10'(gray_ff[3]) << 1) + 10'(gray_ff[6]);
      end
      gx = $signed(12'(pos_s));
      gy = $signed(12'(neg_s));
   end

   always_ff @(posedge clock) begin
      for (int ch = 0; ch < 3; ch++) begin
         lomax_ff[ch]  <= max2(max2(lo_ff[0][ch], lo_ff[1][ch]), lo_ff[2][ch]);
         himin_ff[ch]  <= min2(min2(hi_ff[0][ch], hi_ff[1][ch]), hi_ff[2][ch]);
         medmed_ff[ch] <= med3(md_ff[0][ch], md_ff[1][ch], md_ff[2][ch]);
         gauss_ff[ch]  <= gsum_ff[ch][11:4];
      end
      gpx_ff     <= gray_ff[8];
      sob_ff     <= gx - gy;
      b2_mode_ff <= b1_mode_ff;
      b2_emit_ff <= b1_emit_ff;
      b2_done_ff <= b1_done_ff;
      b2_col_ff  <= b1_col_ff;
      b2_row_ff  <= b1_row_ff;
   end

   always_comb begin
      sob_abs = sob_ff[11] ? 12'(-sob_ff) : 12'(sob_ff);
      sob_val = (sob_abs > 12'd255) ? 8'd255 : sob_abs[7:0];
      case (b2_mode_ff)
         MODE_GRAY:    out_px = {gpx_ff, gpx_ff, gpx_ff};
         MODE_MEDIAN: begin
            for (int ch = 0; ch < 3; ch++) begin
               out_px[ch] = med3(lomax_ff[ch], medmed_ff[ch], himin_ff[ch]);
            end
         end
         MODE_GAUSS:   out_px = gauss_ff;
         MODE_SOBEL_X,
         MODE_SOBEL_Y: out_px = {sob_val, sob_val, sob_val};
         default:      out_px = '0;
      endcase
   end

   assign res_push = b2_valid_ff && b2_emit_ff;
   assign res_drop = b2_valid_ff && !b2_emit_ff;
   assign res.px   = out_px;
   assign res.col  = b2_col_ff;
   assign res.row  = b2_row_ff;
   assign res.done = b2_done_ff;

endmodule
`default_nettype wire

// ===== rtl/core/wf_fifo.sv =====
// Result queue between the back part and the rsp_ ports.
// Depends on wf_pkg for the result type and depth.
`default_nettype none
module wf_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire wf_pkg::result_type  wdata,
   input  wire logic                pop,
   output logic                     empty,
   output wf_pkg::result_type       rdata
);
   import wf_pkg::*;

   localparam int AW = $clog2(QUEUE_DEPTH);

   result_type     mem [QUEUE_DEPTH];
   logic [AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]    count_ff;
   logic           do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign rdata  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + AW'(1);
         end
         count_ff <= count_ff + (AW+1)'(push) - (AW+1)'(do_pop);
      end
   end

endmodule
`default_nettype wire

// ===== sim/window_3x3_image_filter_tb.sv =====
// Self-checking testbench for window_3x3_image_filter: drives pixel frames
// through the push/full side, predicts every filtered result and checks the
// pop/empty side against it. Depends on wf_pkg and the filter RTL.
`default_nettype none
module window_3x3_image_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import wf_pkg::*;

   localparam int        LINE_MAX      = 2048;
   localparam int        ROWS_MAX      = 2048;
   localparam int        CYCLE_LIMIT   = 400000;
   localparam int        SETTLE_CYCLES = 12;
   localparam logic [2:0] MODE_SPARE_LO = 3'd5;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        push;
   logic        full;
   logic [7:0]  req_red_in;
   logic [7:0]  req_green_in;
   logic [7:0]  req_blue_in;
   logic        req_frame_start;
   logic        empty;
   logic        pop;
   logic [7:0]  rsp_red_out;
   logic [7:0]  rsp_green_out;
   logic [7:0]  rsp_blue_out;
   logic [10:0] rsp_out_column;
   logic [10:0] rsp_out_row;
   logic        rsp_frame_done;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [11:0] csr_wdata;

   // predictor state
   pixel_type   upper_line [LINE_MAX];
   pixel_type   middle_line [LINE_MAX];
   pixel_type   win [9];
   int          col_pos;
   int          row_pos;
   logic [2:0]  cfg_mode;
   logic [11:0] cfg_width;
   logic [11:0] cfg_height;

   result_type  pending_results [$];
   int          mismatches;
   int          cycles;
   int          req_idle_pct;
   int          rsp_stall_pct;
   int          hold_left;

   window_3x3_image_filter dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_red_in(req_red_in), .req_green_in(req_green_in),
      .req_blue_in(req_blue_in), .req_frame_start(req_frame_start),
      .empty(empty), .pop(pop),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out), .rsp_out_column(rsp_out_column),
      .rsp_out_row(rsp_out_row), .rsp_frame_done(rsp_frame_done),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic int clamp_size(input logic [11:0] v, input int maxv);
      if (v < 3) return 3;
      if (v > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic logic [7:0] luma(input pixel_type p);
      return 8'((int'(p[2]) + int'(p[1]) + int'(p[0])) / 3);
   endfunction

   function automatic logic [7:0] window_median(input int ch);
      int v [9];
      int t;
      for (int i = 0; i < 9; i++) v[i] = win[i][ch];
      for (int i = 0; i < 9; i++)
         for (int j = 0; j < 8 - i; j++)
            if (v[j] > v[j + 1]) begin
               t = v[j]; v[j] = v[j + 1]; v[j + 1] = t;
            end
      return 8'(v[4]);
   endfunction

   function automatic logic [7:0] window_blur(input int ch);
      int s;
      s = 0;
      for (int i = 0; i < 9; i++)
         s += ((i == 4) ? 4 : (i % 2) ? 2 : 1) * int'(win[i][ch]);
      return 8'(s / 16);
   endfunction

   function automatic logic [7:0] window_gradient(input bit vertical);
      int s;
      int wgt;
      s = 0;
      for (int i = 0; i < 9; i++) begin
         if (vertical)
            wgt = ((i / 3) - 1) * ((i % 3 == 1) ? 2 : 1);
         else
            wgt = ((i % 3) - 1) * ((i / 3 == 1) ? 2 : 1);
         s += wgt * int'(luma(win[i]));
      end
      if (s < 0) s = -s;
      if (s > 255) s = 255;
      return 8'(s);
   endfunction

   task automatic predict_pixel(input pixel_type px, input logic fs);
      int         w;
      int         h;
      int         c;
      int         r;
      bit         emit;
      result_type res;
      w = clamp_size(cfg_width, LINE_MAX);
      h = clamp_size(cfg_height, ROWS_MAX);
      if (fs) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      for (int k = 0; k < 3; k++) begin
         win[3 * k]     = win[3 * k + 1];
         win[3 * k + 1] = win[3 * k + 2];
      end
      win[2] = upper_line[c];
      win[5] = middle_line[c];
      win[8] = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;
      emit     = 1'b0;
      res      = '0;
      res.col  = 11'(c);
      res.row  = 11'(r);
      res.done = (c == w - 1) && (r == h - 1);
      if (cfg_mode == MODE_GRAY) begin
         emit   = 1'b1;
         res.px = {3{luma(px)}};
      end else if (cfg_mode <= MODE_SOBEL_Y && c >= 2 && r >= 2) begin
         emit    = 1'b1;
         res.col = 11'(c - 1);
         res.row = 11'(r - 1);
         if (cfg_mode == MODE_MEDIAN)
            for (int k = 0; k < 3; k++) res.px[k] = window_median(k);
         else if (cfg_mode == MODE_GAUSS)
            for (int k = 0; k < 3; k++) res.px[k] = window_blur(k);
         else
            res.px = {3{window_gradient(cfg_mode == MODE_SOBEL_Y)}};
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
      if (emit) pending_results.push_back(res);
   endtask

   // result side: check every transaction, stall at random or hold off
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            got.px   = {rsp_red_out, rsp_green_out, rsp_blue_out};
            got.col  = rsp_out_column;
            got.row  = rsp_out_row;
            got.done = rsp_frame_done;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result rgb=%h col=%0d row=%0d done=%b",
                           got.px, got.col, got.row, got.done);
            end else begin
               want = pending_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected rgb=%h col=%0d row=%0d done=%b,",
                               " got rgb=%h col=%0d row=%0d done=%b"},
                              want.px, want.col, want.row, want.done,
                              got.px, got.col, got.row, got.done);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_MODE:   cfg_mode   = val[2:0];
         REG_WIDTH:  cfg_width  = val;
         REG_HEIGHT: cfg_height = val;
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic fs);
      if ($urandom_range(99) < req_idle_pct) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      req_frame_start <= fs;
      push            <= 1'b1;
      do @(posedge clock); while (full);
      predict_pixel({r, g, b}, fs);
   endtask

   task automatic drain;
      push <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_chan;
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic test_reset_settings;
      // median at 640 wide: the first row gives no results
      send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
      for (int i = 1; i < 24; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      drain();
   endtask

   task automatic test_edge_frames;
      logic [7:0] v;
      write_reg(REG_WIDTH, 12'd0);
      write_reg(REG_HEIGHT, 12'd1);
      write_reg(REG_MODE, MODE_SOBEL_X);
      for (int i = 0; i < 9; i++) begin
         v = (i % 3 == 2) ? 8'd255 : 8'd0;
         send_pixel(v, v, v, i == 0);
      end
      drain();
      write_reg(REG_MODE, MODE_SOBEL_Y);
      for (int i = 0; i < 9; i++) begin
         v = (i / 3 == 0) ? 8'd255 : 8'd0;
         send_pixel(v, 8'd255 - v, v, i == 0);
      end
      drain();
   endtask

   task automatic test_position_wrap;
      write_reg(REG_MODE, MODE_GAUSS);
      write_reg(REG_WIDTH, 12'd5);
      write_reg(REG_HEIGHT, 12'd4);
      for (int i = 0; i < 8; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
      drain();
      write_reg(REG_WIDTH, 12'd3);
      for (int i = 0; i < 4; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      drain();
      write_reg(REG_HEIGHT, 12'd3);
      for (int i = 0; i < 3; i++) send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b0);
      drain();
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct);
      int         m;
      logic [2:0] md;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int f = 0; f < 3; f++) begin
         m  = $urandom_range(19);
         md = (m < 18) ? 3'(m % 5) : 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
         write_reg(REG_MODE, md);
         write_reg(REG_WIDTH, 12'($urandom_range(3, 12)));
         write_reg(REG_HEIGHT, 12'($urandom_range(3, 8)));
         send_pixel(rand_chan(), rand_chan(), rand_chan(), 1'b1);
         for (int i = 1; i < 47; i++)
            send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(49) == 0);
         drain();
      end
   endtask

   task automatic test_backpressure;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_reg(REG_MODE, MODE_GRAY);
      write_reg(REG_WIDTH, 12'd7);
      write_reg(REG_HEIGHT, 12'd5);
      hold_left = 300;
      for (int i = 0; i < 70; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
      drain();
   endtask

   task automatic test_widest_line;
      req_idle_pct  = 10;
      rsp_stall_pct = 10;
      write_reg(REG_MODE, MODE_GRAY);
      write_reg(REG_WIDTH, 12'd4095);
      write_reg(REG_HEIGHT, 12'd4095);
      for (int i = 0; i < 40; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
      drain();
      write_reg(REG_WIDTH, 12'd2048);
      write_reg(REG_HEIGHT, 12'd2048);
      write_reg(REG_MODE, MODE_SOBEL_Y);
      for (int i = 0; i < 12; i++)
         send_pixel(rand_chan(), rand_chan(), rand_chan(), i == 0);
      drain();
   endtask

   initial begin
      reset           <= 1'b1;
      push            <= 1'b0;
      req_red_in      <= '0;
      req_green_in    <= '0;
      req_blue_in     <= '0;
      req_frame_start <= 1'b0;
      csr_we          <= 1'b0;
      csr_index       <= REG_MODE;
      csr_wdata       <= '0;
      cycles        = 0;
      mismatches    = 0;
      hold_left     = 0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      cfg_mode      = RESET_MODE;
      cfg_width     = RESET_WIDTH;
      cfg_height    = RESET_HEIGHT;
      col_pos       = 0;
      row_pos       = 0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < LINE_MAX; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_edge_frames();
      test_position_wrap();
      test_random_frames(0, 0);
      test_random_frames(45, 0);
      test_random_frames(0, 45);
      test_random_frames(38, 38);
      test_backpressure();
      test_widest_line();

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/wf_pkg.sv
rtl/core/wf_front.sv
rtl/core/wf_back.sv
rtl/core/wf_fifo.sv
rtl/core/window_3x3_image_filter.sv
sim/window_3x3_image_filter_tb.sv
